FILE: hdl/crc_packet_receiver_with_ack_macros.svh
// Assertion macros for the CRC packet receiver.
// Included by the top level; needs nothing else.
`ifndef CRC_PACKET_RECEIVER_WITH_ACK_MACROS_SVH
`define CRC_PACKET_RECEIVER_WITH_ACK_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CRCRX_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CRCRX_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/crcrx_pkg.sv
// Shared types, constants and the CRC-8 byte step for the packet receiver.
// No dependencies.
`default_nettype none

package crcrx_pkg;

  localparam logic [7:0] FILL_BYTE  = 8'hff;
  localparam logic [7:0] LEN_SINGLE = 8'd1;

  localparam logic [7:0] POLY_RST = 8'd7;
  localparam logic [7:0] ACK_RST  = 8'd21;
  localparam logic [7:0] RETX_RST = 8'd25;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLY = 2'd0;
  localparam logic [1:0] CFG_ACK  = 2'd1;
  localparam logic [1:0] CFG_RETX = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SWEEP  = 6'b000010,
    ST_SWLAST = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_GEN    = 6'b010000,
    ST_POP    = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    PH_LEN  = 3'b001,
    PH_DATA = 3'b010,
    PH_CRC  = 3'b100
  } phase_e;

  // Generated packet kinds; the first three also record the last packet sent
  typedef enum logic [1:0] {
    GEN_ZERO  = 2'd0,
    GEN_ACK   = 2'd1,
    GEN_RETX  = 2'd2,
    GEN_EMPTY = 2'd3
  } gen_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } crcrx_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
    logic       packet_available;
  } crcrx_out_t;

  // One word handed to the output stage
  typedef struct packed {
    logic       src_mem;
    logic [7:0] gen_byte;
    logic [1:0] out_kind;
    logic       out_last;
    logic       overflow;
    logic       packet_available;
  } crcrx_issue_t;

  // Non-reflected CRC-8 update by one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/crc_packet_receiver_with_ack.sv
// Fixed-length packet receiver with CRC-8 check, ack and retransmit request.
// Depends on crcrx_pkg, crcrx_out_stage and the assertion macro header.
//
// Usage:
//   Input words carry req_type and rx_byte. A link byte (req_type 0) is
//   framed as length, DATA_BYTES data bytes, then CRC. Length and data bytes
//   are taken one per cycle and give no results. The CRC byte starts a sweep
//   of the frame memory (DATA_BYTES+1 reads, one per cycle) that checks the
//   CRC and copies the frame into the packet memory; a wait state and a
//   decision state follow, then an ack or retransmit-request packet of
//   DATA_BYTES+2 words may go out, one word per cycle unless the output
//   stalls. A pop (req_type 1) streams the head packet from the packet
//   memory at one word per cycle unless the output stalls; an empty pop
//   gives a single word. The input stalls while a sweep or a packet readout
//   is issuing; the next word is taken while the last results still drain
//   from the output stage.
//   Output stall holds the output register and backs up the readout.
//   Configuration writes are taken only while the input is idle.
//   Reset clears the parser, the FIFO pointers, the overflow flag and the
//   last-sent record (the all-zero packet); memories are not cleared.
`default_nettype none

`include "crc_packet_receiver_with_ack_macros.svh"

module crc_packet_receiver_with_ack import crcrx_pkg::*; #(
  parameter int DATA_BYTES = 16,
  parameter int FIFO_DEPTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  crcrx_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output crcrx_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int PKT_LEN  = DATA_BYTES + 2;
  localparam int FS_DEPTH = DATA_BYTES + 1;
  localparam int FS_AW    = $clog2(FS_DEPTH);
  localparam int KW       = $clog2(PKT_LEN);
  localparam int PW       = $clog2(FIFO_DEPTH);
  localparam int FM_DEPTH = FIFO_DEPTH * PKT_LEN;
  localparam int FM_AW    = $clog2(FM_DEPTH);

  localparam logic [FM_AW-1:0] PKT_LEN_A = FM_AW'(PKT_LEN);
  localparam logic [KW-1:0]    K_LAST    = KW'(PKT_LEN - 1);
  localparam logic [FS_AW-1:0] FS_LAST   = FS_AW'(DATA_BYTES);

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [FS_AW-1:0]   pos_q, pos_d;
  logic [7:0]         poly_q, ack_q, retx_q;
  logic [PW-1:0]      wp_q, wp_d, rp_q, rp_d;
  gen_e               last_sent_q, last_sent_d;
  logic               ovf_pend_q, ovf_pend_d;
  logic [KW-1:0]      k_q, k_d;
  logic [7:0]         crc_q, crc_d;
  logic [7:0]         rx_crc_q, rx_crc_d;
  logic               len_one_q, len_one_d;
  logic               is_ack_q, is_ack_d;
  logic               is_retx_q, is_retx_d;
  logic               fill_ok_q, fill_ok_d;
  logic               fr_vld_q;
  logic [FS_AW-1:0]   fr_idx_q;
  logic [7:0]         fr_rd_q;
  gen_e               gen_kind_q, gen_kind_d;
  logic               em_ov_q, em_ov_d;
  logic               em_av_q, em_av_d;
  logic [FM_AW-1:0]   addr_q, addr_d;
  logic [FM_AW-1:0]   wbase_q, wbase_d;
  logic [7:0]         fm_rd_q;

  logic [7:0]         frame_mem [FS_DEPTH];
  logic [7:0]         fifo_mem  [FM_DEPTH];

  logic               in_acc;
  logic               fr_we;
  logic [FS_AW-1:0]   fr_waddr;
  logic               fr_re;
  logic               fm_we;
  logic [FM_AW-1:0]   fm_waddr;
  logic [7:0]         fm_wdata;
  logic               fm_re;
  logic               issue_valid;
  logic               issue_ready;
  crcrx_issue_t       issue;
  logic [7:0]         gen_byte;
  logic [7:0]         gen_code;
  logic [PW-1:0]      wp_nx;
  logic [PW-1:0]      rp_nx;
  logic               single_ok;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wp_nx       = ptr_next(wp_q);
  assign rp_nx       = ptr_next(rp_q);
  assign single_ok   = len_one_q && fill_ok_q;
  assign gen_code    = (gen_kind_q == GEN_ACK) ? ack_q : retx_q;

  // Byte of a generated packet at position k
  always_comb begin
    case (gen_kind_q)
      GEN_ACK, GEN_RETX: begin
        if (k_q == '0) begin
          gen_byte = LEN_SINGLE;
        end else if (k_q == KW'(1)) begin
          gen_byte = gen_code;
        end else if (k_q == K_LAST) begin
          gen_byte = crc_q;
        end else begin
          gen_byte = FILL_BYTE;
        end
      end
      default: gen_byte = 8'd0;
    endcase
  end

  always_comb begin
    issue_valid = (state_q == ST_GEN) || (state_q == ST_POP);
    issue.src_mem          = (state_q == ST_POP);
    issue.gen_byte         = gen_byte;
    issue.overflow         = em_ov_q;
    issue.packet_available = em_av_q;
    if (state_q == ST_POP) begin
      issue.out_kind = KIND_POP;
      issue.out_last = (k_q == K_LAST);
    end else if (gen_kind_q == GEN_EMPTY) begin
      issue.out_kind = KIND_EMPTY;
      issue.out_last = 1'b1;
    end else begin
      issue.out_kind = KIND_TX;
      issue.out_last = (k_q == K_LAST);
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    last_sent_d = last_sent_q;
    ovf_pend_d  = ovf_pend_q;
    k_d         = k_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    len_one_d   = len_one_q;
    is_ack_d    = is_ack_q;
    is_retx_d   = is_retx_q;
    fill_ok_d   = fill_ok_q;
    gen_kind_d  = gen_kind_q;
    em_ov_d     = em_ov_q;
    em_av_d     = em_av_q;
    addr_d      = addr_q;
    wbase_d     = wbase_q;
    fr_we       = 1'b0;
    fr_waddr    = '0;
    fr_re       = 1'b0;
    fm_we       = 1'b0;
    fm_waddr    = wbase_q + FM_AW'(fr_idx_q);
    fm_wdata    = fr_rd_q;
    fm_re       = 1'b0;

    // Frame sweep data: fold into the CRC, check the single-byte pattern, copy
    if (fr_vld_q) begin
      crc_d = crc8_byte(crc_q, fr_rd_q, poly_q);
      fm_we = 1'b1;
      if (fr_idx_q == '0) begin
        len_one_d = (fr_rd_q == LEN_SINGLE);
      end else if (fr_idx_q == FS_AW'(1)) begin
        is_ack_d  = (fr_rd_q == ack_q);
        is_retx_d = (fr_rd_q == retx_q);
      end else begin
        fill_ok_d = fill_ok_q && (fr_rd_q == FILL_BYTE);
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type) begin
            em_ov_d    = ovf_pend_q;
            ovf_pend_d = 1'b0;
            k_d        = '0;
            if (rp_q == wp_q) begin
              gen_kind_d = GEN_EMPTY;
              em_av_d    = 1'b0;
              state_d    = ST_GEN;
            end else begin
              addr_d  = FM_AW'(rp_q) * PKT_LEN_A;
              rp_d    = rp_nx;
              em_av_d = (rp_nx != wp_q);
              state_d = ST_POP;
            end
          end else begin
            case (phase_q)
              PH_DATA: begin
                fr_we    = 1'b1;
                fr_waddr = pos_q + 1'b1;
                if (pos_q == FS_AW'(DATA_BYTES - 1)) begin
                  pos_d   = '0;
                  phase_d = PH_CRC;
                end else begin
                  pos_d = pos_q + 1'b1;
                end
              end
              PH_CRC: begin
                rx_crc_d  = in_data_i.rx_byte;
                phase_d   = PH_LEN;
                k_d       = '0;
                crc_d     = 8'd0;
                len_one_d = 1'b0;
                is_ack_d  = 1'b0;
                is_retx_d = 1'b0;
                fill_ok_d = 1'b1;
                wbase_d   = FM_AW'(wp_q) * PKT_LEN_A;
                state_d   = ST_SWEEP;
              end
              default: begin
                fr_we    = 1'b1;
                fr_waddr = '0;
                pos_d    = '0;
                phase_d  = PH_DATA;
              end
            endcase
          end
        end
      end
      ST_SWEEP: begin
        fr_re = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == KW'(DATA_BYTES)) begin
          state_d = ST_SWLAST;
        end
      end
      ST_SWLAST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Slot at the write pointer is always free: store the CRC byte there
        fm_we    = 1'b1;
        fm_waddr = wbase_q + PKT_LEN_A - 1'b1;
        fm_wdata = rx_crc_q;
        k_d      = '0;
        crc_d    = 8'd0;
        em_ov_d  = ovf_pend_q;
        em_av_d  = (rp_q != wp_q);
        state_d  = ST_GEN;
        if (rx_crc_q != crc_q) begin
          last_sent_d = GEN_RETX;
          gen_kind_d  = GEN_RETX;
          ovf_pend_d  = 1'b0;
        end else if (single_ok && is_ack_q) begin
          state_d = ST_IDLE;
        end else if (single_ok && is_retx_q) begin
          gen_kind_d = last_sent_q;
          ovf_pend_d = 1'b0;
        end else if (wp_nx == rp_q) begin
          // Drop the packet and flag it on the next results
          ovf_pend_d = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          wp_d        = wp_nx;
          last_sent_d = GEN_ACK;
          gen_kind_d  = GEN_ACK;
          ovf_pend_d  = 1'b0;
          em_av_d     = 1'b1;
        end
      end
      ST_GEN: begin
        if (issue_ready) begin
          if ((gen_kind_q == GEN_ACK || gen_kind_q == GEN_RETX) && k_q != K_LAST) begin
            crc_d = crc8_byte(crc_q, gen_byte, poly_q);
          end
          k_d = k_q + 1'b1;
          if (issue.out_last) begin
            k_d     = '0;
            state_d = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (issue_ready) begin
          fm_re  = 1'b1;
          addr_d = addr_q + 1'b1;
          k_d    = k_q + 1'b1;
          if (k_q == K_LAST) begin
            k_d     = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LEN;
      pos_q       <= '0;
      poly_q      <= POLY_RST;
      ack_q       <= ACK_RST;
      retx_q      <= RETX_RST;
      wp_q        <= '0;
      rp_q        <= '0;
      last_sent_q <= GEN_ZERO;
      ovf_pend_q  <= 1'b0;
      k_q         <= '0;
      gen_kind_q  <= GEN_ZERO;
      fr_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      last_sent_q <= last_sent_d;
      ovf_pend_q  <= ovf_pend_d;
      k_q         <= k_d;
      gen_kind_q  <= gen_kind_d;
      fr_vld_q    <= fr_re;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_POLY: poly_q <= cfg_data_i;
          CFG_ACK:  ack_q  <= cfg_data_i;
          CFG_RETX: retx_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q     <= crc_d;
    rx_crc_q  <= rx_crc_d;
    len_one_q <= len_one_d;
    is_ack_q  <= is_ack_d;
    is_retx_q <= is_retx_d;
    fill_ok_q <= fill_ok_d;
    em_ov_q   <= em_ov_d;
    em_av_q   <= em_av_d;
    addr_q    <= addr_d;
    wbase_q   <= wbase_d;
    fr_idx_q  <= k_q[FS_AW-1:0];
  end

  // Frame store
  always_ff @(posedge clk_i) begin
    if (fr_we) begin
      frame_mem[fr_waddr] <= in_data_i.rx_byte;
    end
    if (fr_re) begin
      fr_rd_q <= frame_mem[k_q[FS_AW-1:0]];
    end
  end

  // Packet FIFO store
  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fifo_mem[fm_waddr] <= fm_wdata;
    end
    if (fm_re) begin
      fm_rd_q <= fifo_mem[addr_q];
    end
  end

  crcrx_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_i       (issue),
    .issue_ready_o (issue_ready),
    .mem_byte_i    (fm_rd_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  `CRCRX_ASSERT_NXT(a_sweep_end, clk_i, rst_ni, fr_vld_q && fr_idx_q == FS_LAST, state_q == ST_DECIDE, "frame sweep did not end in decide")
  `CRCRX_ASSERT_IMP(a_no_sweep_on_accept, clk_i, rst_ni, in_acc, !fr_vld_q, "word accepted during frame sweep")
  `CRCRX_ASSERT_IMP(a_empty_pop_word, clk_i, rst_ni, out_valid_o && out_data_o.out_kind == KIND_EMPTY, out_data_o.out_byte == 8'd0 && out_data_o.out_last, "bad empty-pop word")

endmodule

`default_nettype wire

FILE: hdl/crcrx_out_stage.sv
// Two-stage output pipeline: a byte stage behind the packet memory read
// register and the output register. Depends on crcrx_pkg.
`default_nettype none

module crcrx_out_stage import crcrx_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         issue_valid_i,
  input  crcrx_issue_t issue_i,
  output logic         issue_ready_o,
  input  logic [7:0]   mem_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output crcrx_out_t   out_data_o
);

  logic         s1_vld_q;
  crcrx_issue_t s1_q;
  logic         out_valid_q;
  crcrx_out_t   out_q;
  logic         s2_free;
  logic         s1_move;

  assign s2_free       = !out_valid_q || !out_stall_i;
  assign s1_move       = s1_vld_q && s2_free;
  assign issue_ready_o = !s1_vld_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue_valid_i && issue_ready_o) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The memory read register holds while the byte stage waits
  always_ff @(posedge clk_i) begin
    if (issue_valid_i && issue_ready_o) begin
      s1_q <= issue_i;
    end
    if (s1_move) begin
      out_q.out_kind         <= s1_q.out_kind;
      out_q.out_byte         <= s1_q.src_mem ? mem_byte_i : s1_q.gen_byte;
      out_q.out_last         <= s1_q.out_last;
      out_q.overflow         <= s1_q.overflow;
      out_q.packet_available <= s1_q.packet_available;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for crc_packet_receiver_with_ack: drives link bytes and pops,
// predicts every reply, popped packet and overflow flag, and checks each output word.
// Depends on crcrx_pkg and the crc_packet_receiver_with_ack RTL.
`default_nettype none

module testbench;
  import crcrx_pkg::*;

  localparam int DATA_BYTES = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int PKT_LEN    = DATA_BYTES + 2;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 20000;

  typedef logic [PKT_LEN-1:0][7:0] packet_t;
  typedef enum logic [1:0] {AWAIT_LEN, AWAIT_DATA, AWAIT_CRC} frame_phase_e;
  typedef enum logic [2:0] {PK_DATA, PK_ACK, PK_RETX, PK_BADCRC, PK_NEAR} pkt_flavor_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  crcrx_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  crcrx_out_t out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  crc_packet_receiver_with_ack #(
    .DATA_BYTES(DATA_BYTES),
    .FIFO_DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver model state
  logic [7:0]   poly_r = POLY_RST;
  logic [7:0]   ack_r  = ACK_RST;
  logic [7:0]   retx_r = RETX_RST;
  frame_phase_e phase = AWAIT_LEN;
  int           data_idx = 0;
  packet_t      frame = '0;
  packet_t      held_packets[$];
  gen_e         last_sent = GEN_ZERO;
  logic         ovf_pending = 1'b0;
  crcrx_out_t   awaited_words[$];

  // Run bookkeeping
  bit idle_en = 1'b1;
  int mismatches = 0;
  int n_link_bytes = 0;
  int n_pops = 0;
  int n_results = 0;
  int n_settings = 0;
  int hold_orders = 0;
  int hold_length = 0;
  int hold_served = 0;
  int hold_left = 0;
  crcrx_out_t next_word;

  function automatic logic [7:0] frame_crc(packet_t p);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i <= DATA_BYTES; i++) begin
      c = c ^ p[i];
      for (int b = 0; b < 8; b++) begin
        c = c[7] ? ((c << 1) ^ poly_r) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic packet_t seal(packet_t p);
    packet_t s;
    s = p;
    s[PKT_LEN-1] = frame_crc(p);
    return s;
  endfunction

  function automatic packet_t single_packet(logic [7:0] code);
    packet_t p;
    p = '0;
    p[0] = LEN_SINGLE;
    p[1] = code;
    for (int k = 2; k <= DATA_BYTES; k++) p[k] = FILL_BYTE;
    return seal(p);
  endfunction

  function automatic bit frame_is_single(logic [7:0] code);
    packet_t s;
    s = single_packet(code);
    s[PKT_LEN-1] = frame[PKT_LEN-1];
    return s == frame;
  endfunction

  function automatic void queue_packet(packet_t p, logic [1:0] kind);
    crcrx_out_t r;
    for (int k = 0; k < PKT_LEN; k++) begin
      r.out_kind         = kind;
      r.out_byte         = p[k];
      r.out_last         = (k == PKT_LEN - 1);
      r.overflow         = ovf_pending;
      r.packet_available = (held_packets.size() != 0);
      awaited_words.push_back(r);
    end
    ovf_pending = 1'b0;
  endfunction

  // Ack and retransmit packets are rebuilt from the current codes and polynomial
  function automatic void queue_generated(gen_e g);
    packet_t p;
    case (g)
      GEN_ACK:  p = single_packet(ack_r);
      GEN_RETX: p = single_packet(retx_r);
      default:  p = '0;
    endcase
    queue_packet(p, KIND_TX);
  endfunction

  function automatic void reply_for_word(crcrx_in_t w);
    crcrx_out_t r;
    packet_t    p;
    if (w.req_type) begin
      if (held_packets.size() == 0) begin
        r.out_kind         = KIND_EMPTY;
        r.out_byte         = 8'h00;
        r.out_last         = 1'b1;
        r.overflow         = ovf_pending;
        r.packet_available = 1'b0;
        awaited_words.push_back(r);
        ovf_pending = 1'b0;
      end else begin
        p = held_packets.pop_front();
        queue_packet(p, KIND_POP);
      end
    end else begin
      case (phase)
        AWAIT_DATA: begin
          frame[1 + data_idx] = w.rx_byte;
          data_idx++;
          if (data_idx == DATA_BYTES) begin
            data_idx = 0;
            phase = AWAIT_CRC;
          end
        end
        AWAIT_CRC: begin
          phase = AWAIT_LEN;
          if (w.rx_byte != frame_crc(frame)) begin
            last_sent = GEN_RETX;
            queue_generated(GEN_RETX);
          end else if (frame_is_single(ack_r)) begin
            // drop: valid acks need no answer
          end else if (frame_is_single(retx_r)) begin
            queue_generated(last_sent);
          end else if (held_packets.size() == FIFO_DEPTH - 1) begin
            ovf_pending = 1'b1;
          end else begin
            p = frame;
            p[PKT_LEN-1] = w.rx_byte;
            held_packets.push_back(p);
            last_sent = GEN_ACK;
            queue_generated(GEN_ACK);
          end
        end
        default: begin
          frame[0] = w.rx_byte;
          data_idx = 0;
          phase = AWAIT_DATA;
        end
      endcase
    end
  endfunction

  function automatic packet_t make_packet(pkt_flavor_e flavor);
    packet_t p;
    int      spot;
    for (int k = 0; k < PKT_LEN; k++) p[k] = 8'($urandom_range(0, 255));
    case (flavor)
      PK_ACK:  p = single_packet(ack_r);
      PK_RETX: p = single_packet(retx_r);
      PK_NEAR: begin
        p = single_packet($urandom_range(0, 1) ? ack_r : retx_r);
        spot = $urandom_range(0, DATA_BYTES);
        p[spot] = p[spot] ^ 8'($urandom_range(1, 255));
        p = seal(p);
      end
      default: p = seal(p);
    endcase
    if (flavor == PK_BADCRC) p[PKT_LEN-1] = p[PKT_LEN-1] ^ 8'($urandom_range(1, 255));
    return p;
  endfunction

  // Enter and leave at a falling edge; valid stays high for a following word
  task automatic send_word(input logic req, input logic [7:0] value);
    crcrx_in_t w;
    w.req_type = req;
    w.rx_byte  = value;
    while (idle_en && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply_for_word(w);
    if (req) n_pops++;
    else n_link_bytes++;
    @(negedge clk_i);
  endtask

  task automatic send_pop();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input packet_t p);
    for (int k = 0; k < PKT_LEN; k++) send_word(1'b0, p[k]);
  endtask

  task automatic send_link_packet(input pkt_flavor_e flavor);
    send_frame(make_packet(flavor));
  endtask

  // Finish a partial frame with random bytes
  task automatic align_frame();
    while (phase != AWAIT_LEN) send_word(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // Drain all replies, then give a silent CRC sweep time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [7:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_POLY: poly_r = value;
      CFG_ACK:  ack_r  = value;
      CFG_RETX: retx_r = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [7:0] poly, input logic [7:0] ack,
                               input logic [7:0] retx);
    align_frame();
    write_register(CFG_POLY, poly);
    write_register(CFG_ACK, ack);
    write_register(CFG_RETX, retx);
    n_settings++;
  endtask

  task automatic test_empty_and_zero_resend();
    send_pop();
    send_link_packet(PK_RETX);
    send_link_packet(PK_RETX);
  endtask

  task automatic test_crc_and_codes();
    send_link_packet(PK_BADCRC);
    send_link_packet(PK_RETX);
    send_link_packet(PK_ACK);
  endtask

  // Fill the FIFO with no idling; the near miss lands on a full FIFO
  task automatic test_overflow();
    idle_en = 1'b0;
    repeat (FIFO_DEPTH - 1) send_link_packet(PK_DATA);
    send_link_packet(PK_NEAR);
    idle_en = 1'b1;
  endtask

  // Hold the output for a long stretch while pops keep coming
  task automatic test_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_length = HOLD_CYCLES;
    hold_orders++;
    @(negedge clk_i);
    repeat (FIFO_DEPTH) send_pop();
  endtask

  task automatic test_register_settings();
    apply_setting(8'h00, 8'h00, 8'hff);
    send_link_packet(PK_RETX);
    apply_setting(POLY_RST, ACK_RST, RETX_RST);
  endtask

  always @(negedge clk_i) begin
    if (hold_orders != hold_served) begin
      hold_served = hold_orders;
      hold_left   = hold_length;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(0, 99) < 22);
    end
  end

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual %h", $time, out_data_o);
      end else begin
        next_word = awaited_words.pop_front();
        n_results++;
        check_field("out_kind", 8'(next_word.out_kind), 8'(out_data_o.out_kind));
        check_field("out_byte", next_word.out_byte, out_data_o.out_byte);
        check_field("out_last", 8'(next_word.out_last), 8'(out_data_o.out_last));
        check_field("overflow", 8'(next_word.overflow), 8'(out_data_o.overflow));
        check_field("packet_available", 8'(next_word.packet_available),
                    8'(out_data_o.packet_available));
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POLY;
    cfg_data_i  = 8'h00;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_and_zero_resend();
    test_crc_and_codes();
    test_overflow();
    test_backpressure();
    test_register_settings();

    settle();
    $display("Covered %0d link bytes and %0d pops, %0d output words checked,",
             n_link_bytes, n_pops, n_results);
    $display("over %0d register settings beyond reset, with overflow and a long output hold.",
             n_settings);
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("crc_packet_receiver_with_ack regression: pass");
    end else begin
      $display("crc_packet_receiver_with_ack regression: fail");
    end
    $finish;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Timed out with %0d words outstanding", awaited_words.size());
    $display("crc_packet_receiver_with_ack regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

FILE: crc_packet_receiver_with_ack.f
+incdir+hdl
hdl/crcrx_pkg.sv
hdl/crcrx_out_stage.sv
hdl/crc_packet_receiver_with_ack.sv
verif/testbench.sv
